// ===== rtl/cht_pkg.sv =====
package cht_pkg;

   localparam int FRAC_BITS   = 16;
   localparam int MAX_SAMPLES = 64;
   localparam int DEN_W       = $clog2(MAX_SAMPLES);
   localparam int SPS_W       = 7;
   localparam logic [SPS_W-1:0] SPS_RESET = 7'd16;

   typedef logic signed [31:0] coord_type;

   typedef struct packed {
      coord_type x;
      coord_type y;
      coord_type z;
   } vec_type;

   typedef struct packed {
      vec_type          p0;
      vec_type          p1;
      vec_type          m0;
      vec_type          m1;
      logic [DEN_W-1:0] den;
   } seg_type;

endpackage

// ===== rtl/cht_front.sv =====
module cht_front (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_stall,
   input  cht_pkg::coord_type        req_ctrl_x,
   input  cht_pkg::coord_type        req_ctrl_y,
   input  cht_pkg::coord_type        req_ctrl_z,
   input  logic                      csr_wr_en,
   input  logic [cht_pkg::SPS_W-1:0] csr_wr_data,
   input  logic                      q_full,
   output logic                      q_push,
   output cht_pkg::seg_type          q_seg
);

   logic [1:0]                slot_ff, slot_in;
   logic [cht_pkg::SPS_W-1:0] sps_ff, sps_in;
   cht_pkg::vec_type          p0_ff, p1_ff, m0_ff;
   cht_pkg::vec_type          cur;
   logic                      accept;
   logic [cht_pkg::SPS_W-1:0] n_clamped;

   assign cur       = '{x: req_ctrl_x, y: req_ctrl_y, z: req_ctrl_z};
   assign req_stall = (slot_ff == 2'd3) && q_full;
   assign accept    = req_valid && !req_stall;
   assign q_push    = accept && (slot_ff == 2'd3);

   always_comb begin
      if (sps_ff < 7'd2) begin
         n_clamped = 7'd2;
      end else if (sps_ff > 7'(cht_pkg::MAX_SAMPLES)) begin
         n_clamped = 7'(cht_pkg::MAX_SAMPLES);
      end else begin
         n_clamped = sps_ff;
      end
   end

   always_comb begin
      q_seg.p0  = p0_ff;
      q_seg.p1  = p1_ff;
      q_seg.m0  = m0_ff;
      q_seg.m1  = cur;
      q_seg.den = cht_pkg::DEN_W'(n_clamped - 7'd1);
   end

   assign slot_in = accept ? slot_ff + 2'd1 : slot_ff;
   assign sps_in  = csr_wr_en ? csr_wr_data : sps_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         slot_ff <= 2'd0;
         sps_ff  <= cht_pkg::SPS_RESET;
      end else begin
         slot_ff <= slot_in;
         sps_ff  <= sps_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         case (slot_ff)
            2'd0: p0_ff <= cur;
            2'd1: p1_ff <= cur;
            2'd2: m0_ff <= cur;
            default: ;
         endcase
      end
   end

endmodule

// ===== rtl/cht_queue.sv =====
module cht_queue (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  cht_pkg::seg_type push_seg,
   output logic             full,
   input  logic             pop,
   output logic             head_valid,
   output cht_pkg::seg_type head_seg
);

   cht_pkg::seg_type mem [2];
   logic             wr_ptr_ff, wr_ptr_in;
   logic             rd_ptr_ff, rd_ptr_in;
   logic [1:0]       count_ff, count_in;

   assign full       = (count_ff == 2'd2);
   assign head_valid = (count_ff != 2'd0);
   assign head_seg   = mem[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? !rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem[wr_ptr_ff] <= push_seg;
      end
   end

endmodule

// ===== rtl/cht_back.sv =====
module cht_back (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      q_valid,
   input  cht_pkg::seg_type          q_seg,
   output logic                      q_pop,
   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output cht_pkg::coord_type        rsp_pos_x,
   output cht_pkg::coord_type        rsp_pos_y,
   output cht_pkg::coord_type        rsp_pos_z,
   output logic [cht_pkg::DEN_W-1:0] rsp_sample_index,
   output logic                      rsp_last_sample
);

   localparam int F  = cht_pkg::FRAC_BITS;
   localparam int DW = cht_pkg::DEN_W;
   localparam int TW = F + 1;
   localparam int QB = F + 2;
   localparam int SW = $clog2(QB);
   localparam int RW = DW + 2;
   localparam int HW = F + 4;
   localparam int PW = HW + 32;
   localparam int AW = PW + 4;
   localparam logic signed [AW-1:0] SAT_HI = AW'(64'sd2147483647);
   localparam logic signed [AW-1:0] SAT_LO = AW'(-64'sd2147483648);

   typedef enum logic [6:0] {
      S_IDLE = 7'b0000001,
      S_DIV  = 7'b0000010,
      S_T2   = 7'b0000100,
      S_T3   = 7'b0001000,
      S_WGT  = 7'b0010000,
      S_MAC  = 7'b0100000,
      S_EMIT = 7'b1000000
   } state_type;

   state_type              state_ff, state_in;
   logic [SW-1:0]          step_ff, step_in;
   logic [RW-1:0]          rem_ff, rem_in;
   logic [QB-1:0]          quo_ff, quo_in;
   logic [TW-1:0]          qs_ff, qs_in;
   logic [RW-1:0]          rs_ff, rs_in;
   logic [TW-1:0]          t_ff, t_in;
   logic [RW-1:0]          r_ff, r_in;
   logic [TW-1:0]          t2_ff, t2_in;
   logic [TW-1:0]          t3_ff, t3_in;
   logic signed [HW-1:0]   h_ff [4];
   logic signed [HW-1:0]   h_in [4];
   logic [1:0]             c_ff, c_in, k_ff, k_in;
   logic signed [AW-1:0]   acc_ff, acc_in;
   logic signed [AW-1:0]   cacc_ff [3];
   logic [DW-1:0]          i_ff, i_in;

   logic                   out_free, rsp_load;
   logic [RW-1:0]          dsor, rem_sh, r_sum;
   logic [2*TW-1:0]        sq;
   logic signed [HW-1:0]   ts, t2s, t3s;
   cht_pkg::vec_type       vsel;
   cht_pkg::coord_type     v;
   logic signed [PW-1:0]   prod;

   function automatic cht_pkg::coord_type round_sat(input logic signed [AW-1:0] a);
      logic signed [AW-1:0] s;
      s = (a + AW'(64'sd1 <<< (F - 1))) >>> F;
      if (s > SAT_HI) begin
         return SAT_HI[31:0];
      end else if (s < SAT_LO) begin
         return SAT_LO[31:0];
      end
      return s[31:0];
   endfunction

   assign out_free = !rsp_valid || !rsp_stall;
   assign rsp_load = (state_ff == S_EMIT) && out_free;
   assign q_pop    = rsp_load && (i_ff == q_seg.den);

   assign dsor   = {1'b0, q_seg.den, 1'b0};
   assign rem_sh = {rem_ff[RW-2:0], (step_ff == SW'(QB - 1))};
   assign r_sum  = r_ff + rs_ff;

   always_comb begin
      case (state_ff)
         S_T2:    sq = (2*TW)'(t_ff) * (2*TW)'(t_ff);
         default: sq = (2*TW)'(t2_ff) * (2*TW)'(t_ff);
      endcase
   end

   assign ts  = $signed(HW'(t_ff));
   assign t2s = $signed(HW'(t2_ff));
   assign t3s = $signed(HW'(t3_ff));

   always_comb begin
      case (k_ff)
         2'd0:    vsel = q_seg.p0;
         2'd1:    vsel = q_seg.p1;
         2'd2:    vsel = q_seg.m0;
         default: vsel = q_seg.m1;
      endcase
      case (c_ff)
         2'd0:    v = vsel.x;
         2'd1:    v = vsel.y;
         default: v = vsel.z;
      endcase
   end

   assign prod = h_ff[k_ff] * v;

   always_comb begin
      state_in = state_ff;
      step_in  = step_ff;
      rem_in   = rem_ff;
      quo_in   = quo_ff;
      qs_in    = qs_ff;
      rs_in    = rs_ff;
      t_in     = t_ff;
      r_in     = r_ff;
      t2_in    = t2_ff;
      t3_in    = t3_ff;
      h_in     = h_ff;
      c_in     = c_ff;
      k_in     = k_ff;
      acc_in   = acc_ff;
      i_in     = i_ff;
      case (state_ff)
         S_IDLE: begin
            if (q_valid) begin
               step_in  = SW'(QB - 1);
               rem_in   = '0;
               quo_in   = '0;
               state_in = S_DIV;
            end
         end
         S_DIV: begin
            rem_in = rem_sh;
            if (rem_sh >= dsor) begin
               rem_in          = rem_sh - dsor;
               quo_in[step_ff] = 1'b1;
            end
            step_in = step_ff - SW'(1);
            if (step_ff == '0) begin
               qs_in    = TW'(quo_in);
               rs_in    = rem_in;
               t_in     = '0;
               r_in     = RW'(q_seg.den);
               i_in     = '0;
               state_in = S_T2;
            end
         end
         S_T2: begin
            t2_in    = TW'((sq + (2*TW)'(1 << (F - 1))) >> F);
            state_in = S_T3;
         end
         S_T3: begin
            t3_in    = TW'((sq + (2*TW)'(1 << (F - 1))) >> F);
            state_in = S_WGT;
         end
         S_WGT: begin
            h_in[0]  = HW'(1 << F) - (t2s + t2s + t2s) + (t3s + t3s);
            h_in[1]  = (t2s + t2s + t2s) - (t3s + t3s);
            h_in[2]  = ts - (t2s + t2s) + t3s;
            h_in[3]  = t3s - t2s;
            c_in     = 2'd0;
            k_in     = 2'd0;
            state_in = S_MAC;
         end
         S_MAC: begin
            acc_in = ((k_ff == 2'd0) ? '0 : acc_ff) + {{(AW - PW){prod[PW-1]}}, prod};
            k_in   = k_ff + 2'd1;
            if (k_ff == 2'd3) begin
               c_in = c_ff + 2'd1;
               if (c_ff == 2'd2) begin
                  state_in = S_EMIT;
               end
            end
         end
         S_EMIT: begin
            if (out_free) begin
               i_in = i_ff + DW'(1);
               if (r_sum >= dsor) begin
                  r_in = r_sum - dsor;
                  t_in = t_ff + qs_ff + TW'(1);
               end else begin
                  r_in = r_sum;
                  t_in = t_ff + qs_ff;
               end
               state_in = (i_ff == q_seg.den) ? S_IDLE : S_T2;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_IDLE;
         rsp_valid <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (rsp_load) begin
            rsp_valid <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      step_ff <= step_in;
      rem_ff  <= rem_in;
      quo_ff  <= quo_in;
      qs_ff   <= qs_in;
      rs_ff   <= rs_in;
      t_ff    <= t_in;
      r_ff    <= r_in;
      t2_ff   <= t2_in;
      t3_ff   <= t3_in;
      h_ff    <= h_in;
      c_ff    <= c_in;
      k_ff    <= k_in;
      acc_ff  <= acc_in;
      i_ff    <= i_in;
      if ((state_ff == S_MAC) && (k_ff == 2'd3)) begin
         cacc_ff[c_ff] <= acc_in;
      end
      if (rsp_load) begin
         rsp_pos_x        <= round_sat(cacc_ff[0]);
         rsp_pos_y        <= round_sat(cacc_ff[1]);
         rsp_pos_z        <= round_sat(cacc_ff[2]);
         rsp_sample_index <= i_ff;
         rsp_last_sample  <= (i_ff == q_seg.den);
      end
   end

endmodule

// ===== rtl/cubic_hermite_curve_tessellator.sv =====
// The fourth word of a group completes a segment; its first sample comes after a start
// state, a bit-serial restoring divide for the t increment, and that sample's own steps.
// Each sample runs the T2, T3, weight, MAC and emit states in turn; the MAC step uses one
// multiplier for all twelve products, and emit waits while the output is stalled.
// A two-entry segment queue lets the front keep taking words while the back end is busy.
// Reset is synchronous and active high; the sample count returns to 16.
module cubic_hermite_curve_tessellator (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_stall,
   input  cht_pkg::coord_type        req_ctrl_x,
   input  cht_pkg::coord_type        req_ctrl_y,
   input  cht_pkg::coord_type        req_ctrl_z,
   input  logic                      csr_wr_en,
   input  logic [cht_pkg::SPS_W-1:0] csr_wr_data,
   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output cht_pkg::coord_type        rsp_pos_x,
   output cht_pkg::coord_type        rsp_pos_y,
   output cht_pkg::coord_type        rsp_pos_z,
   output logic [cht_pkg::DEN_W-1:0] rsp_sample_index,
   output logic                      rsp_last_sample
);

   logic             q_full, q_push, q_pop, q_valid;
   cht_pkg::seg_type push_seg, head_seg;

   cht_front u_front (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_ctrl_x  (req_ctrl_x),
      .req_ctrl_y  (req_ctrl_y),
      .req_ctrl_z  (req_ctrl_z),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .q_full      (q_full),
      .q_push      (q_push),
      .q_seg       (push_seg)
   );

   cht_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (q_push),
      .push_seg   (push_seg),
      .full       (q_full),
      .pop        (q_pop),
      .head_valid (q_valid),
      .head_seg   (head_seg)
   );

   cht_back u_back (
      .clock            (clock),
      .reset            (reset),
      .q_valid          (q_valid),
      .q_seg            (head_seg),
      .q_pop            (q_pop),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_pos_x        (rsp_pos_x),
      .rsp_pos_y        (rsp_pos_y),
      .rsp_pos_z        (rsp_pos_z),
      .rsp_sample_index (rsp_sample_index),
      .rsp_last_sample  (rsp_last_sample)
   );

endmodule
